// ----- hw/rtl/ptc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg: shared constants of the point-in-triangle crossings core
// Default coordinate width and the width of the two result counts.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH     = 2;

endpackage
`default_nettype wire

// ----- hw/rtl/ptc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_if: item channels of the point-in-triangle crossings core
// A query channel with the point and three vertices, and a result channel
// with the two counts.
// ----------------------------------------------------------------------------
interface ptc_query_if #(
  parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;
  logic signed [COORD_WIDTH-1:0] query_z;
  logic signed [COORD_WIDTH-1:0] vertex0_x;
  logic signed [COORD_WIDTH-1:0] vertex0_y;
  logic signed [COORD_WIDTH-1:0] vertex0_z;
  logic signed [COORD_WIDTH-1:0] vertex1_x;
  logic signed [COORD_WIDTH-1:0] vertex1_y;
  logic signed [COORD_WIDTH-1:0] vertex1_z;
  logic signed [COORD_WIDTH-1:0] vertex2_x;
  logic signed [COORD_WIDTH-1:0] vertex2_y;
  logic signed [COORD_WIDTH-1:0] vertex2_z;

  modport source (
    output valid, query_x, query_y, query_z,
    output vertex0_x, vertex0_y, vertex0_z,
    output vertex1_x, vertex1_y, vertex1_z,
    output vertex2_x, vertex2_y, vertex2_z,
    input  ready
  );

  modport sink (
    input  valid, query_x, query_y, query_z,
    input  vertex0_x, vertex0_y, vertex0_z,
    input  vertex1_x, vertex1_y, vertex1_z,
    input  vertex2_x, vertex2_y, vertex2_z,
    output ready
  );
endinterface

interface ptc_result_if;
  logic                            valid;
  logic                            ready;
  logic [ptc_pkg::COUNT_WIDTH-1:0] crossings;
  logic [ptc_pkg::COUNT_WIDTH-1:0] edge_hits;

  modport source (output valid, crossings, edge_hits, input ready);
  modport sink (input valid, crossings, edge_hits, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ptc_normal.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_normal: normal, dominant axis and projection
// Five stages: edge vectors, cross terms, normal components, magnitudes,
// then the choice of axis and the projected, point-relative vertices.
// ----------------------------------------------------------------------------
module ptc_normal #(
  parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [COORD_WIDTH-1:0] q [3],
  input  logic signed [COORD_WIDTH-1:0] p [3][3],
  output logic signed [COORD_WIDTH:0]   u [3],
  output logic signed [COORD_WIDTH:0]   v [3]
);
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] e2 [3];
  logic signed [DW-1:0] d_a [3][3];
  logic signed [DW-1:0] d_b [3][3];
  logic signed [DW-1:0] d_c [3][3];
  logic signed [DW-1:0] d_d [3][3];
  logic signed [PW-1:0] m [6];
  logic signed [NW-1:0] n [3];
  logic        [NW-1:0] mag [3];
  logic                 x_dom;
  logic                 z_dom;

  always_comb begin
    x_dom = (mag[0] >= mag[1]) && (mag[0] >= mag[2]);
    z_dom = !x_dom && (mag[1] < mag[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= DW'(p[1][k]) - DW'(p[0][k]);
        e2[k] <= DW'(p[2][k]) - DW'(p[0][k]);
        for (int i = 0; i < 3; i++) begin
          d_a[i][k] <= DW'(p[i][k]) - DW'(q[k]);
        end
      end

      m[0] <= PW'(e1[1]) * PW'(e2[2]);
      m[1] <= PW'(e1[2]) * PW'(e2[1]);
      m[2] <= PW'(e1[2]) * PW'(e2[0]);
      m[3] <= PW'(e1[0]) * PW'(e2[2]);
      m[4] <= PW'(e1[0]) * PW'(e2[1]);
      m[5] <= PW'(e1[1]) * PW'(e2[0]);
      d_b  <= d_a;

      for (int k = 0; k < 3; k++) begin
        n[k] <= NW'(m[2*k]) - NW'(m[2*k+1]);
      end
      d_c <= d_b;

      for (int k = 0; k < 3; k++) begin
        mag[k] <= n[k][NW-1] ? $unsigned(-n[k]) : $unsigned(n[k]);
      end
      d_d <= d_c;

      for (int i = 0; i < 3; i++) begin
        u[i] <= x_dom ? d_d[i][1] : d_d[i][0];
        v[i] <= z_dom ? d_d[i][1] : d_d[i][2];
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ptc_edge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_edge: crossing test over the three triangle edges
// One stage forms the two cross terms and side flags of each edge; the
// sign of their difference then decides each edge and the counts follow.
// ----------------------------------------------------------------------------
module ptc_edge #(
  parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            adv,
  input  logic signed [COORD_WIDTH:0]     u [3],
  input  logic signed [COORD_WIDTH:0]     v [3],
  output logic [ptc_pkg::COUNT_WIDTH-1:0] crossings,
  output logic [ptc_pkg::COUNT_WIDTH-1:0] edge_hits
);
  import ptc_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  typedef struct packed {
    logic straddle;
    logic both_pos;
    logic one_pos;
    logic rising;
  } edge_flags_t;

  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];
  edge_flags_t          flags [3];
  logic                 hit [3];
  logic                 crossed [3];

  for (genvar j = 0; j < 3; j++) begin : g_edge
    localparam int A = j;
    localparam int B = (j + 1) % 3;

    logic signed [NW-1:0] diff;
    logic                 zero;
    logic                 neg;
    logic                 pos_a;
    logic                 pos_b;

    assign pos_a = !u[A][DW-1] && (u[A] != '0);
    assign pos_b = !u[B][DW-1] && (u[B] != '0);

    always_ff @(posedge clk) begin
      if (adv) begin
        pa[j]             <= PW'(u[A]) * PW'(v[B]);
        pb[j]             <= PW'(v[A]) * PW'(u[B]);
        flags[j].straddle <= v[A][DW-1] != v[B][DW-1];
        flags[j].both_pos <= pos_a && pos_b;
        flags[j].one_pos  <= pos_a || pos_b;
        flags[j].rising   <= v[B] > v[A];
      end
    end

    always_comb begin
      diff       = NW'(pa[j]) - NW'(pb[j]);
      zero       = (diff == '0);
      neg        = diff[NW-1];
      hit[j]     = flags[j].straddle && !flags[j].both_pos && flags[j].one_pos && zero;
      crossed[j] = flags[j].straddle &&
                   (flags[j].both_pos ||
                    (flags[j].one_pos &&
                     (zero || (!neg && flags[j].rising) || (neg && !flags[j].rising))));
    end
  end

  assign crossings = COUNT_WIDTH'(crossed[0]) + COUNT_WIDTH'(crossed[1]) +
                     COUNT_WIDTH'(crossed[2]);
  assign edge_hits = COUNT_WIDTH'(hit[0]) + COUNT_WIDTH'(hit[1]) + COUNT_WIDTH'(hit[2]);

endmodule
`default_nettype wire

// ----- hw/rtl/point_in_triangle_crossings_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_triangle_crossings_core: ray crossing test of a point in a triangle
// Projects the triangle onto the plane that drops the dominant normal axis
// and counts the edges that a ray along +u from the query point crosses.
//
//   channel  role    payload
//   query    sink    query_x/y/z, vertex0..2_x/y/z, signed coordinates
//   result   source  crossings, edge_hits, 2-bit counts
//
// One item is accepted every cycle while no held result stalls the pipeline.
// The pipeline has eight register stages, two of them after multiplier
// banks.
// Reset clears every stage's valid bit and the result valid bit, and holds
// query.ready low.
// A result held by the sink freezes the whole pipeline and drops query.ready.
// ----------------------------------------------------------------------------
module point_in_triangle_crossings_core #(
  parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  ptc_query_if.sink    query,
  ptc_result_if.source result
);
  import ptc_pkg::*;

  localparam int NSTAGE = 7;

  logic                          adv;
  logic [NSTAGE-1:0]             vld;
  logic                          res_valid;
  logic [COUNT_WIDTH-1:0]        res_crossings;
  logic [COUNT_WIDTH-1:0]        res_edge_hits;
  logic signed [COORD_WIDTH-1:0] q [3];
  logic signed [COORD_WIDTH-1:0] p [3][3];
  logic signed [COORD_WIDTH:0]   u [3];
  logic signed [COORD_WIDTH:0]   v [3];
  logic [COUNT_WIDTH-1:0]        crossings;
  logic [COUNT_WIDTH-1:0]        edge_hits;

  assign adv         = !res_valid || result.ready;
  assign query.ready = adv && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NSTAGE-2:0], query.valid};
      res_valid <= vld[NSTAGE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q[0]          <= query.query_x;
      q[1]          <= query.query_y;
      q[2]          <= query.query_z;
      p[0][0]       <= query.vertex0_x;
      p[0][1]       <= query.vertex0_y;
      p[0][2]       <= query.vertex0_z;
      p[1][0]       <= query.vertex1_x;
      p[1][1]       <= query.vertex1_y;
      p[1][2]       <= query.vertex1_z;
      p[2][0]       <= query.vertex2_x;
      p[2][1]       <= query.vertex2_y;
      p[2][2]       <= query.vertex2_z;
      res_crossings <= crossings;
      res_edge_hits <= edge_hits;
    end
  end

  ptc_normal #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_normal (
    .clk(clk),
    .adv(adv),
    .q  (q),
    .p  (p),
    .u  (u),
    .v  (v)
  );

  ptc_edge #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_edge (
    .clk      (clk),
    .adv      (adv),
    .u        (u),
    .v        (v),
    .crossings(crossings),
    .edge_hits(edge_hits)
  );

  assign result.valid     = res_valid;
  assign result.crossings = res_crossings;
  assign result.edge_hits = res_edge_hits;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !query.ready |-> result.valid)
    else $error("query stalled with no result waiting");

  a_last_stage_lands: assert property (@(posedge clk) disable iff (rst)
    (vld[NSTAGE-1] && adv) |=> result.valid)
    else $error("item in the last stage did not reach the result register");

  a_hits_within_crossings: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.crossings >= result.edge_hits))
    else $error("more edge hits than crossings");
`endif

endmodule
`default_nettype wire

// ----- tb/point_in_triangle_crossings_core_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_triangle_crossings_core_tb: self-checking bench for the crossings core
// Sends directed and random point/triangle items through the query channel,
// predicts the crossing and edge-hit counts of each with exact wide integer
// arithmetic, and compares every result item in order. Both channels idle at
// random, the result side holds off long enough to stall the pipeline, and
// the stimulus pauses until the pipeline has drained between phases.
// ----------------------------------------------------------------------------
module point_in_triangle_crossings_core_tb;

  localparam int CW             = ptc_pkg::COORD_WIDTH_DEF;
  localparam int NW             = ptc_pkg::COUNT_WIDTH;
  localparam int PHASE_ITEMS    = 560;
  localparam int PRESSURE_HOLD  = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [127:0]   wide_t;

  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};

  // Row 0 is the query point, rows 1 to 3 are the vertices; columns are x, y, z.
  typedef struct {
    coord_t pt[4][3];
  } tri_query_t;

  typedef struct packed {
    logic [NW-1:0] crossings;
    logic [NW-1:0] edge_hits;
  } count_pair_t;

  typedef enum int {EDGE_MISS, EDGE_CROSS, EDGE_ON} edge_kind_t;

  class crossings_scoreboard;
    count_pair_t expected_q[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    static function wide_t wide_mul(input longint a, input longint b);
      wide_t wa;
      wide_t wb;
      wa = a;
      wb = b;
      return wa * wb;
    endfunction

    static function wide_t magnitude(input wide_t x);
      return (x < 0) ? -x : x;
    endfunction

    static function edge_kind_t classify_edge(input longint ua, input longint va,
                                              input longint ub, input longint vb);
      wide_t sc;
      if ((va < 0) == (vb < 0)) return EDGE_MISS;
      if (ua > 0 && ub > 0) return EDGE_CROSS;
      if (!(ua > 0) && !(ub > 0)) return EDGE_MISS;
      sc = wide_mul(ua, vb) - wide_mul(va, ub);
      if (sc == 0) return EDGE_ON;
      if ((sc > 0) == (vb > va)) return EDGE_CROSS;
      return EDGE_MISS;
    endfunction

    static function count_pair_t predict_counts(input tri_query_t t);
      longint      c[4][3];
      longint      e1[3];
      longint      e2[3];
      wide_t       nrm[3];
      longint      u[3];
      longint      w[3];
      int          au;
      int          av;
      int          ncs;
      int          nes;
      edge_kind_t  kind;
      count_pair_t r;
      for (int i = 0; i < 4; i++)
        for (int a = 0; a < 3; a++) c[i][a] = t.pt[i][a];
      for (int a = 0; a < 3; a++) begin
        e1[a] = c[2][a] - c[1][a];
        e2[a] = c[3][a] - c[1][a];
      end
      nrm[0] = magnitude(wide_mul(e1[1], e2[2]) - wide_mul(e1[2], e2[1]));
      nrm[1] = magnitude(wide_mul(e1[2], e2[0]) - wide_mul(e1[0], e2[2]));
      nrm[2] = magnitude(wide_mul(e1[0], e2[1]) - wide_mul(e1[1], e2[0]));
      if (nrm[0] >= nrm[1] && nrm[0] >= nrm[2]) begin
        au = 1;
        av = 2;
      end else if (nrm[1] >= nrm[2]) begin
        au = 0;
        av = 2;
      end else begin
        au = 0;
        av = 1;
      end
      for (int i = 0; i < 3; i++) begin
        u[i] = c[i+1][au] - c[0][au];
        w[i] = c[i+1][av] - c[0][av];
      end
      ncs = 0;
      nes = 0;
      for (int i = 0; i < 3; i++) begin
        kind = classify_edge(u[i], w[i], u[(i+1)%3], w[(i+1)%3]);
        if (kind != EDGE_MISS) ncs++;
        if (kind == EDGE_ON) nes++;
      end
      r.crossings = ncs[NW-1:0];
      r.edge_hits = nes[NW-1:0];
      return r;
    endfunction

    function void note_query(input tri_query_t t);
      expected_q.insert(expected_q.size(), predict_counts(t));
    endfunction

    function void check_result(input logic [NW-1:0] crossings,
                               input logic [NW-1:0] edge_hits);
      count_pair_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item crossings=%0d edge_hits=%0d",
                 $time, crossings, edge_hits);
        return;
      end
      want = expected_q.pop_front();
      if (crossings !== want.crossings) begin
        errors++;
        $display("%0t: crossings mismatch: expected %0d, actual %0d",
                 $time, want.crossings, crossings);
      end
      if (edge_hits !== want.edge_hits) begin
        errors++;
        $display("%0t: edge_hits mismatch: expected %0d, actual %0d",
                 $time, want.edge_hits, edge_hits);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ptc_query_if #(.COORD_WIDTH(CW)) query_ch ();
  ptc_result_if                    result_ch ();

  point_in_triangle_crossings_core #(.COORD_WIDTH(CW)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch)
  );

  crossings_scoreboard board = new();

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_req_seq = 0;
  int stall_cycles = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst || (query_ch.valid && query_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("point_in_triangle_crossings_core_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : result_sink
    int hold_left;
    int hold_ack_seq;
    hold_left = 0;
    hold_ack_seq = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready)
        board.check_result(result_ch.crossings, result_ch.edge_hits);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_req_seq != hold_ack_seq) begin
        hold_ack_seq = hold_req_seq;
        hold_left = PRESSURE_HOLD;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  function automatic tri_query_t build_query(
      input coord_t qx, input coord_t qy, input coord_t qz,
      input coord_t ax, input coord_t ay, input coord_t az,
      input coord_t bx, input coord_t by, input coord_t bz,
      input coord_t cx, input coord_t cy, input coord_t cz);
    tri_query_t t;
    t.pt[0][0] = qx; t.pt[0][1] = qy; t.pt[0][2] = qz;
    t.pt[1][0] = ax; t.pt[1][1] = ay; t.pt[1][2] = az;
    t.pt[2][0] = bx; t.pt[2][1] = by; t.pt[2][2] = bz;
    t.pt[3][0] = cx; t.pt[3][1] = cy; t.pt[3][2] = cz;
    return t;
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(5))
      0:       return CMIN;
      1:       return CMAX;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Structured items place the vertices close to the query point so that
  // inside hits, vertices on the ray and exact edge hits come up often.
  function automatic tri_query_t random_query();
    tri_query_t t;
    coord_t     base[3];
    int         mode;
    int         span;
    int         flat_axis;
    int         flat_off;
    int         offset;
    mode = $urandom_range(99);
    span = (mode < 65) ? 4 : ((mode < 85) ? 1000 : (1 << 20));
    flat_axis = $urandom_range(5);
    flat_off = int'($urandom_range(2 * span)) - span;
    for (int a = 0; a < 3; a++) base[a] = coord_t'($urandom);
    for (int i = 0; i < 4; i++) begin
      for (int a = 0; a < 3; a++) begin
        if (mode < 20) begin
          t.pt[i][a] = coord_t'($urandom);
        end else if (mode < 30) begin
          t.pt[i][a] = extreme_coord();
        end else begin
          offset = int'($urandom_range(2 * span)) - span;
          if (i > 0 && a == flat_axis) offset = flat_off;
          t.pt[i][a] = base[a] + coord_t'(offset);
        end
      end
    end
    return t;
  endfunction

  task automatic send_query(input tri_query_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid     <= 1'b1;
    query_ch.query_x   <= t.pt[0][0];
    query_ch.query_y   <= t.pt[0][1];
    query_ch.query_z   <= t.pt[0][2];
    query_ch.vertex0_x <= t.pt[1][0];
    query_ch.vertex0_y <= t.pt[1][1];
    query_ch.vertex0_z <= t.pt[1][2];
    query_ch.vertex1_x <= t.pt[2][0];
    query_ch.vertex1_y <= t.pt[2][1];
    query_ch.vertex1_z <= t.pt[2][2];
    query_ch.vertex2_x <= t.pt[3][0];
    query_ch.vertex2_y <= t.pt[3][1];
    query_ch.vertex2_z <= t.pt[3][2];
    do @(posedge clk); while (!query_ch.ready);
    board.note_query(t);
  endtask

  task automatic wait_drained();
    query_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    tri_query_t directed_q[$];
    rst = 1'b1;
    query_ch.valid = 1'b0;
    query_ch.query_x = '0;
    query_ch.query_y = '0;
    query_ch.query_z = '0;
    query_ch.vertex0_x = '0;
    query_ch.vertex0_y = '0;
    query_ch.vertex0_z = '0;
    query_ch.vertex1_x = '0;
    query_ch.vertex1_y = '0;
    query_ch.vertex1_z = '0;
    query_ch.vertex2_x = '0;
    query_ch.vertex2_y = '0;
    query_ch.vertex2_z = '0;

    directed_q.insert(directed_q.size(), build_query(1, 1, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
    directed_q.insert(directed_q.size(), build_query(5, 5, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
    directed_q.insert(directed_q.size(), build_query(2, 0, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
    directed_q.insert(directed_q.size(), build_query(0, 2, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
    directed_q.insert(directed_q.size(), build_query(2, 2, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
    directed_q.insert(directed_q.size(), build_query(0, 0, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
    directed_q.insert(directed_q.size(), build_query(-3, 1, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
    directed_q.insert(directed_q.size(), build_query(1, 1, 0, 0, 0, 0, 0, 4, 0, 4, 0, 0));
    directed_q.insert(directed_q.size(), build_query(0, 1, 1, 0, 0, 0, 0, 4, 0, 0, 0, 4));
    directed_q.insert(directed_q.size(), build_query(1, 0, 1, 0, 0, 0, 0, 0, 4, 4, 0, 0));
    directed_q.insert(directed_q.size(), build_query(0, 0, 0, 0, 0, 0, 1, -1, 0, 0, 0, 1));
    directed_q.insert(directed_q.size(), build_query(0, 0, 0, 0, 0, 0, 0, 1, -1, 1, 0, 0));
    directed_q.insert(directed_q.size(), build_query(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    directed_q.insert(directed_q.size(), build_query(0, 0, 0, 3, 3, 3, 3, 3, 3, 3, 3, 3));
    directed_q.insert(directed_q.size(), build_query(0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3));
    directed_q.insert(directed_q.size(), build_query(1, 0, 0, 3, 0, 0, 0, -2, 0, 0, 2, 0));
    directed_q.insert(directed_q.size(),
                      build_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                  CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    directed_q.insert(directed_q.size(),
                      build_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                                  CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    directed_q.insert(directed_q.size(),
                      build_query(0, 0, 0, CMIN, CMIN, 0,
                                  CMAX, CMIN, 0, CMIN, CMAX, 0));
    directed_q.insert(directed_q.size(),
                      build_query(CMAX, CMAX, 0, CMIN, CMIN, 0,
                                  CMAX, CMIN, 0, CMIN, CMAX, 0));
    directed_q.insert(directed_q.size(),
                      build_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                  CMIN, CMAX, CMIN, CMAX, CMIN, CMAX));
    directed_q.insert(directed_q.size(),
                      build_query(32'h8000, 32'h8000, 32'h10000,
                                  0, 0, 32'h10000,
                                  32'h10000, 0, 32'h10000,
                                  0, 32'h10000, 32'h10000));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 19;
    sink_idle_pct <= 50;
    foreach (directed_q[i]) send_query(directed_q[i]);
    repeat (PHASE_ITEMS) send_query(random_query());
    wait_drained();

    src_idle_pct = 50;
    sink_idle_pct <= 19;
    repeat (PHASE_ITEMS) send_query(random_query());
    wait_drained();

    // The result side holds off while items keep coming, so the pipeline
    // fills and the query channel has to stall.
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    hold_req_seq <= hold_req_seq + 1;
    repeat (PHASE_ITEMS) send_query(random_query());
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("point_in_triangle_crossings_core_tb: done, clean");
    end else begin
      $display("point_in_triangle_crossings_core_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- point_in_triangle_crossings_core.f -----
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_if.sv
hw/rtl/ptc_normal.sv
hw/rtl/ptc_edge.sv
hw/rtl/point_in_triangle_crossings_core.sv
tb/point_in_triangle_crossings_core_tb.sv
